[src/ssdc_pkg.sv]
package ssdc_pkg;

    // request command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_CHAR = 2'd1;
    localparam logic [1:0] CMD_INT  = 2'd2;

    // configuration register indexes
    localparam logic REG_DIGIT_COUNT = 1'b0;
    localparam logic REG_UPSIDE_DOWN = 1'b1;

    // character codes used by the integer writer and the decoder
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_A     = 8'd65;
    localparam logic [7:0] CH_Z     = 8'd90;

    localparam logic [7:0] PAT_UNKNOWN = 8'h20;

    // reciprocal of ten, exact for magnitudes up to 43689
    localparam logic [15:0] RECIP_TEN  = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    // segment table: digits, letters, then minus
    localparam logic [7:0] SEG_TABLE [37] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6,
        8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E, 8'hC6, 8'h6E, 8'h20, 8'h78,
        8'h6E, 8'h1C, 8'h2B, 8'h2A, 8'hFC, 8'hCE, 8'h3B, 8'h0A, 8'hB7, 8'h62,
        8'h7C, 8'h7D, 8'h38, 8'h6F, 8'h76, 8'h9E, 8'h02
    };

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_sub;
        logic out_load;
        logic wr_char;
        logic wr_neg;
        logic wr_digit;
    } ssdc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_ge_n;
        logic out_free;
        logic int_last;
    } ssdc_stat_t;

    function automatic logic [7:0] char_pattern(input logic [7:0] ch);
        logic [7:0] pat;
        pat = PAT_UNKNOWN;
        if (ch inside {[CH_ZERO:CH_NINE]})
            pat = SEG_TABLE[6'(ch - CH_ZERO)];
        else if (ch inside {[CH_A:CH_Z]})
            pat = SEG_TABLE[6'(ch - CH_A + 8'd10)];
        else if (ch == CH_MINUS)
            pat = SEG_TABLE[36];
        else if (ch == CH_SPACE)
            pat = 8'h00;
        return pat;
    endfunction

    // swap segments abc with def for inverted mounting
    function automatic logic [7:0] swap_halves(input logic [7:0] c);
        return {c[4:2], c[7:5], c[1:0]};
    endfunction

endpackage

[src/ssdc_if.sv]
interface ssdc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [2:0]         position;
    logic [7:0]         character;
    logic               point;
    logic signed [15:0] number;

    modport source (output valid, command, position, character, point, number,
                    input ready);
    modport sink   (input valid, command, position, character, point, number,
                    output ready);
endinterface

interface ssdc_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] active_digit;
    logic [7:0] segments;

    modport source (output valid, active_digit, segments, input ready);
    modport sink   (input valid, active_digit, segments, output ready);
endinterface

[src/ssdc_ctrl.sv]
module ssdc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [1:0]         req_command,
    input  ssdc_pkg::ssdc_stat_t stat,
    output logic               req_ready,
    output ssdc_pkg::ssdc_cmd_t  cmd
);
    import ssdc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_SHOW = 3'd2;
    localparam logic [2:0] S_CHAR = 3'd3;
    localparam logic [2:0] S_NEG  = 3'd4;
    localparam logic [2:0] S_INT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    case (req_command)
                        CMD_TICK: state_next = S_MOD;
                        CMD_CHAR: state_next = S_CHAR;
                        CMD_INT:  state_next = S_NEG;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_MOD:
            begin
                if (stat.scan_ge_n)
                    cmd.scan_sub = 1'b1;
                else
                    state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_CHAR:
            begin
                cmd.wr_char = 1'b1;
                state_next  = S_IDLE;
            end
            S_NEG:
            begin
                cmd.wr_neg = 1'b1;
                state_next = S_INT;
            end
            S_INT:
            begin
                cmd.wr_digit = 1'b1;
                if (stat.int_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[src/ssdc_dp.sv]
module ssdc_dp #(
    parameter int MAX_DIGITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [3:0]         cfg_wdata,
    input  logic [2:0]         req_position,
    input  logic [7:0]         req_character,
    input  logic               req_point,
    input  logic signed [15:0] req_number,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output logic [2:0]         rsp_active_digit,
    output logic [7:0]         rsp_segments,
    input  ssdc_pkg::ssdc_cmd_t  cmd,
    output ssdc_pkg::ssdc_stat_t stat
);
    import ssdc_pkg::*;

    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int SW = $clog2(MAX_DIGITS + 3);
    localparam int PW = (CW > 3) ? CW : 3;

    logic [3:0]    digit_count_reg;
    logic          upside_down_reg;
    logic [7:0]    store_reg [MAX_DIGITS];
    logic [IW-1:0] scan_pos_reg;
    logic [SW-1:0] work_reg;
    logic [2:0]    pos_reg;
    logic [7:0]    char_reg;
    logic          point_reg;
    logic [15:0]   val_reg;
    logic          neg_reg;
    logic          first_reg;
    logic [IW-1:0] cnt_reg;
    logic          out_valid_reg;
    logic [2:0]    out_digit_reg;
    logic [7:0]    out_seg_reg;

    logic [CW-1:0] n;
    logic [1:0]    step;
    logic [15:0]   mag;
    logic [31:0]   prod;
    logic [12:0]   quot;
    logic [15:0]   rem;
    logic [7:0]    digit_char;
    logic          wr_en;
    logic [PW-1:0] wpos;
    logic [7:0]    wchar;
    logic          wdp;
    logic [PW-1:0] mpos;
    logic [7:0]    wpat;
    logic [IW-1:0] widx;

    // digit count in use, saturated to the supported range
    always_comb
    begin
        if (digit_count_reg < 4'd2)
            n = CW'(2);
        else if ({1'b0, digit_count_reg} > 5'(MAX_DIGITS))
            n = CW'(MAX_DIGITS);
        else
            n = CW'(digit_count_reg);
    end

    assign step = n[0] ? 2'd2 : 2'd3;
    assign mag  = req_number[15] ? 16'(-req_number) : 16'(req_number);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= 4'd4;
            upside_down_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DIGIT_COUNT: digit_count_reg <= cfg_wdata;
                REG_UPSIDE_DOWN: upside_down_reg <= cfg_wdata[0];
                default:         digit_count_reg <= digit_count_reg;
            endcase
        end
    end

    // divide by ten, one decimal digit per cycle
    assign prod       = val_reg * RECIP_TEN;
    assign quot       = prod[31:RECIP_SHIFT];
    assign rem        = val_reg - (16'(quot) << 3) - (16'(quot) << 1);
    assign digit_char = (first_reg || (val_reg != 16'd0)) ? CH_ZERO + 8'(rem[3:0]) : CH_SPACE;

    // write source select
    always_comb
    begin
        wr_en = 1'b0;
        wpos  = '0;
        wchar = CH_SPACE;
        wdp   = 1'b0;
        if (cmd.wr_char)
        begin
            wr_en = 1'b1;
            wpos  = PW'(pos_reg);
            wchar = char_reg;
            wdp   = point_reg;
        end
        else if (cmd.wr_neg)
        begin
            wr_en = neg_reg;
            wchar = CH_MINUS;
        end
        else if (cmd.wr_digit)
        begin
            wr_en = 1'b1;
            wpos  = PW'(cnt_reg);
            wchar = digit_char;
        end
    end

    // character encode, mirror and segment swap
    assign mpos = PW'(n) - PW'(1) - wpos;
    assign wpat = (upside_down_reg ? swap_halves(char_pattern(wchar)) : char_pattern(wchar))
                  | {7'd0, wdp};
    assign widx = upside_down_reg ? IW'(mpos) : IW'(wpos);

    // digit store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
                store_reg[i] <= 8'h00;
        end
        else if (wr_en && (wpos < PW'(n)))
        begin
            store_reg[widx] <= wpat;
        end
    end

    // request capture and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_reg   <= req_position;
            char_reg  <= req_character;
            point_reg <= req_point;
            val_reg   <= mag;
            neg_reg   <= req_number[15];
            first_reg <= 1'b1;
            cnt_reg   <= IW'(n - CW'(1));
            work_reg  <= SW'(scan_pos_reg) + SW'(step);
        end
        else
        begin
            if (cmd.scan_sub)
                work_reg <= work_reg - SW'(n);
            if (cmd.wr_digit)
            begin
                val_reg   <= 16'(quot);
                first_reg <= 1'b0;
                cnt_reg   <= cnt_reg - IW'(1);
            end
        end
    end

    // scan position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_pos_reg <= '0;
        else if (cmd.out_load)
            scan_pos_reg <= IW'(work_reg);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_digit_reg <= 3'(work_reg);
            out_seg_reg   <= store_reg[IW'(work_reg)];
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_active_digit = out_digit_reg;
    assign rsp_segments     = out_seg_reg;

    // status to the controller
    assign stat.scan_ge_n = (work_reg >= SW'(n));
    assign stat.out_free  = !out_valid_reg || rsp_ready;
    assign stat.int_last  = (cnt_reg == IW'(neg_reg));

endmodule

[src/seven_segment_display_controller_unit.sv]
// channel  | direction | payload
// ---------+-----------+------------------------------------------------
// req      | in        | command, position, character, point, number
// rsp      | out       | active_digit, segments (tick requests only)
// cfg      | in        | cfg_wr_en, cfg_index, cfg_wdata (write only)
//
// one request at a time; a tick subtracts the digit count from the scan position as the scan
// wraps, then waits for a free output register; a character write is a single store write
// an integer write stores a minus sign when negative, then the digits in use (one less when
// negative) from the divide-by-ten loop, which produces one decimal digit per cycle
// reset blanks all digits, scan position 0, digit count 4, no inversion
// a stalled result holds only a tick in its final state; writes keep going
module seven_segment_display_controller_unit #(
    parameter int MAX_DIGITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    ssdc_req_if.sink   req,
    ssdc_rsp_if.source rsp,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [3:0] cfg_wdata
);
    import ssdc_pkg::*;

    ssdc_cmd_t  cmd;
    ssdc_stat_t stat;

    // sequencer
    ssdc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .stat        (stat),
        .req_ready   (req.ready),
        .cmd         (cmd)
    );

    // digit store, scan and encode datapath
    ssdc_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .req_position     (req.position),
        .req_character    (req.character),
        .req_point        (req.point),
        .req_number       (req.number),
        .rsp_ready        (rsp.ready),
        .rsp_valid        (rsp.valid),
        .rsp_active_digit (rsp.active_digit),
        .rsp_segments     (rsp.segments),
        .cmd              (cmd),
        .stat             (stat)
    );

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    // a result is loaded only into a free output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result overwrote a pending one");

    // a new result follows an output load
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(cmd.out_load))
        else $error("result without a tick");

    // no store write or scan work while a request is being taken
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !(cmd.wr_char || cmd.wr_neg || cmd.wr_digit || cmd.scan_sub))
        else $error("work in progress while ready");

endmodule

[dv/seven_segment_display_controller_unit_tb.sv]
module seven_segment_display_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssdc_pkg::*;

    localparam int          DISPLAY_SLOTS = 8;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          CYCLE_LIMIT   = 500000;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;

    typedef struct {
        logic [1:0]         command;
        logic [2:0]         position;
        logic [7:0]         character;
        logic               point;
        logic signed [15:0] number;
    } display_req_t;

    typedef struct {
        logic [2:0] active_digit;
        logic [7:0] segments;
    } scan_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_index;
    logic [3:0] cfg_wdata;

    ssdc_req_if req_bus ();
    ssdc_rsp_if rsp_bus ();

    // display shadow: digit store, scan pointer and register copies
    logic [7:0]   digit_store [DISPLAY_SLOTS];
    int           scan_pos;
    logic [3:0]   cfg_count;
    logic         cfg_flip;
    scan_result_t expected_scans [$];

    int          mismatches = 0;
    int          req_idle_pct = 0;
    int          rsp_idle_pct = 0;
    int unsigned rsp_hold_left = 0;
    int unsigned cycle_count = 0;

    seven_segment_display_controller_unit #(
        .MAX_DIGITS(DISPLAY_SLOTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_bus),
        .rsp      (rsp_bus),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // digit count saturated to the usable range
    function automatic int digits_in_use();
        if (cfg_count < 2)
            return 2;
        if (cfg_count > DISPLAY_SLOTS)
            return DISPLAY_SLOTS;
        return int'(cfg_count);
    endfunction

    // decode one character into the store, mirrored when mounted upside down
    function automatic void store_glyph(input int pos, input logic [7:0] ch, input logic dp);
        int         n;
        int         slot;
        logic [7:0] g;
        n = digits_in_use();
        slot = pos;
        if (ch >= CH_ZERO && ch <= CH_NINE)
            g = SEG_TABLE[ch - CH_ZERO];
        else if (ch >= CH_A && ch <= CH_Z)
            g = SEG_TABLE[ch - CH_A + 10];
        else if (ch == CH_MINUS)
            g = SEG_TABLE[36];
        else if (ch == CH_SPACE)
            g = 8'h00;
        else
            g = PAT_UNKNOWN;
        if (slot >= n)
            return;
        if (cfg_flip)
        begin
            slot = n - 1 - slot;
            g = ((g & 8'hE0) >> 3) | ((g & 8'h1C) << 3) | (g & 8'h03);
        end
        digit_store[slot] = g | {7'b0, dp};
    endfunction

    // update the shadow for one accepted request, queue the scan result of a tick
    function automatic void predict_request(input display_req_t r);
        int           n;
        int           pos;
        int           lead;
        int unsigned  mag;
        scan_result_t res;
        n = digits_in_use();
        case (r.command)
            CMD_TICK:
            begin
                scan_pos = (scan_pos + ((n % 2 == 0) ? 3 : 2)) % n;
                res.active_digit = 3'(scan_pos);
                res.segments = digit_store[scan_pos];
                expected_scans.push_back(res);
            end
            CMD_CHAR:
                store_glyph(int'(r.position), r.character, r.point);
            CMD_INT:
            begin
                mag = 32'(unsigned'(r.number));
                lead = 0;
                pos = n - 1;
                if (r.number < 0)
                begin
                    mag = 32'h10000 - mag;
                    lead = 1;
                    store_glyph(0, CH_MINUS, 1'b0);
                end
                // digits right-aligned, low digit first, excess dropped
                while (pos >= lead && mag > 0)
                begin
                    store_glyph(pos, 8'(CH_ZERO + mag % 10), 1'b0);
                    mag = mag / 10;
                    pos--;
                end
                // zero shows a lone digit at the right
                if (pos == n - 1)
                begin
                    store_glyph(pos, CH_ZERO, 1'b0);
                    pos--;
                end
                while (pos >= lead)
                begin
                    store_glyph(pos, CH_SPACE, 1'b0);
                    pos--;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic display_req_t make_request(input logic [1:0] cmd, input logic [2:0] pos,
                                                  input logic [7:0] ch, input logic dp,
                                                  input logic signed [15:0] num);
        display_req_t r;
        r.command = cmd;
        r.position = pos;
        r.character = ch;
        r.point = dp;
        r.number = num;
        return r;
    endfunction

    // offer one request, with random idle cycles in front of it
    task automatic send_request(input display_req_t r);
        if ($urandom_range(99) < req_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < req_idle_pct);
        end
        req_bus.valid <= 1'b1;
        req_bus.command <= r.command;
        req_bus.position <= r.position;
        req_bus.character <= r.character;
        req_bus.point <= r.point;
        req_bus.number <= r.number;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        predict_request(r);
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_request(make_request(CMD_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)),
                                      1'($urandom_range(1)), 16'($urandom)));
    endtask

    // stop offering, wait for every result, then let any write finish
    task automatic wait_until_idle();
        req_bus.valid <= 1'b0;
        while (expected_scans.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [3:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DIGIT_COUNT)
            cfg_count = val;
        else
            cfg_flip = val[0];
        @(posedge clk);
    endtask

    // blank store and scan order after reset, default four digits
    task automatic test_power_on_scan();
        send_ticks(4);
    endtask

    // character decoding, decimal point, ignored positions and unused command
    task automatic test_character_writes();
        send_request(make_request(CMD_CHAR, 3'd0, CH_ZERO, 1'b0, 16'sd0));
        send_request(make_request(CMD_CHAR, 3'd1, CH_NINE, 1'b1, 16'sd0));
        send_request(make_request(CMD_CHAR, 3'd2, CH_A, 1'b0, 16'sd0));
        send_request(make_request(CMD_CHAR, 3'd3, CH_Z, 1'b1, 16'sd0));
        send_ticks(4);
        send_request(make_request(CMD_CHAR, 3'd0, CH_MINUS, 1'b0, 16'sd0));
        send_request(make_request(CMD_CHAR, 3'd1, 8'hFF, 1'b1, 16'sd0));
        send_request(make_request(CMD_CHAR, 3'd2, 8'h00, 1'b0, 16'sd0));
        send_request(make_request(CMD_CHAR, 3'd3, CH_SPACE, 1'b1, 16'sd0));
        send_request(make_request(CMD_CHAR, 3'd7, CH_A, 1'b1, 16'sd0));
        send_request(make_request(CMD_UNUSED, 3'd1, CH_NINE, 1'b1, -16'sd1));
        send_ticks(4);
    endtask

    // most negative value, saturated digit count, inverted mounting
    task automatic test_integer_writes();
        wait_until_idle();
        write_register(REG_DIGIT_COUNT, 4'd15);
        write_register(REG_UPSIDE_DOWN, 4'd1);
        send_request(make_request(CMD_INT, 3'd0, 8'd0, 1'b0, -16'sd32768));
        send_ticks(4);
        send_request(make_request(CMD_INT, 3'd7, 8'hFF, 1'b1, 16'sd32767));
        send_ticks(4);
    endtask

    // random requests in blocks, each block under a fresh register setting
    task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                       input int unsigned target);
        display_req_t r;
        int unsigned  sent;
        int unsigned  sel;
        int unsigned  k;
        logic [3:0]   count_val;
        sent = 0;
        req_idle_pct = sender_idle;
        rsp_idle_pct = receiver_idle;
        while (sent < target)
        begin
            wait_until_idle();
            sel = $urandom_range(11);
            case (sel)
                0: count_val = 4'd0;
                1: count_val = 4'd1;
                2: count_val = 4'd2;
                3: count_val = 4'd8;
                4: count_val = 4'd9;
                5: count_val = 4'd15;
                default: count_val = 4'($urandom_range(15));
            endcase
            write_register(REG_DIGIT_COUNT, count_val);
            write_register(REG_UPSIDE_DOWN, 4'($urandom_range(15)));
            repeat ($urandom_range(20, 60))
            begin
                r = make_request(CMD_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)),
                                 1'($urandom_range(1)), 16'($urandom));
                sel = $urandom_range(99);
                if (sel >= 45 && sel < 75)
                begin
                    r.command = CMD_CHAR;
                    // mostly displayable codes, some arbitrary bytes
                    k = $urandom_range(47);
                    if (k < 10)
                        r.character = 8'(CH_ZERO + k);
                    else if (k < 36)
                        r.character = 8'(CH_A + k - 10);
                    else if (k == 36)
                        r.character = CH_MINUS;
                    else if (k == 37)
                        r.character = CH_SPACE;
                end
                else if (sel >= 75 && sel < 95)
                begin
                    r.command = CMD_INT;
                    k = $urandom_range(7);
                    case (k)
                        1: r.number = 16'sd0;
                        2: r.number = 16'sd32767;
                        3: r.number = -16'sd32768;
                        4: r.number = -16'sd1;
                        5: r.number = 16'($urandom_range(99));
                        6: r.number = 16'($urandom_range(9999));
                        default: r.number = 16'($urandom);
                    endcase
                    if (k >= 5 && $urandom_range(1))
                        r.number = -r.number;
                end
                else if (sel >= 95)
                    r.command = CMD_UNUSED;
                send_request(r);
                if (r.command != CMD_UNUSED)
                    sent++;
            end
        end
    endtask

    // long receiver hold while ticks keep coming, then a full drain
    task automatic test_output_backpressure();
        wait_until_idle();
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        @(negedge clk);
        rsp_hold_left = 200;
        @(posedge clk);
        send_ticks(24);
        wait_until_idle();
    endtask

    // receiver: random idling, or a long hold when one is requested
    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_left != 0)
            begin
                rsp_bus.ready <= 1'b0;
                rsp_hold_left--;
            end
            else
                rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // compare each accepted scan result with the oldest prediction
    always @(posedge clk)
    begin : check_scan
        scan_result_t want;
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (expected_scans.size() == 0)
            begin
                mismatches++;
                $error("unexpected result: active_digit %0d segments %02h",
                       rsp_bus.active_digit, rsp_bus.segments);
            end
            else
            begin
                want = expected_scans.pop_front();
                if (rsp_bus.active_digit !== want.active_digit)
                begin
                    mismatches++;
                    $error("active_digit: expected %0d, actual %0d",
                           want.active_digit, rsp_bus.active_digit);
                end
                if (rsp_bus.segments !== want.segments)
                begin
                    mismatches++;
                    $error("segments: expected %02h, actual %02h",
                           want.segments, rsp_bus.segments);
                end
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.command <= CMD_TICK;
        req_bus.position <= 3'd0;
        req_bus.character <= 8'd0;
        req_bus.point <= 1'b0;
        req_bus.number <= 16'sd0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_DIGIT_COUNT;
        cfg_wdata <= 4'd0;
        foreach (digit_store[i])
            digit_store[i] = 8'h00;
        scan_pos = 0;
        cfg_count = 4'd4;
        cfg_flip = 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_scan();
        test_character_writes();
        test_integer_writes();
        test_random_traffic(34, 54, 265);
        test_random_traffic(54, 34, 265);
        test_output_backpressure();
        test_random_traffic(0, 0, 265);
        wait_until_idle();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
